// ===== hw/rtl/dsa_pkg.sv =====
// ----------------------------------------------------------------------------
// dsa_pkg
// Shared types and constants for the descriptive statistics accumulator.
// ----------------------------------------------------------------------------
package dsa_pkg;

  localparam int SAMPLE_W    = 16;
  localparam int CNT_W       = 13;
  localparam int SUM_W       = 28;
  localparam int SQ_W        = 43;
  localparam int AVG_W       = 24;
  localparam int SPR_W       = 40;
  localparam int FRAC_BITS   = 8;
  localparam int MAX_SAMPLES = 4096;

  // n * sum of squares and sum * sum, both products this wide
  localparam int PROD_W = CNT_W + SQ_W;
  // dividend of the shared divider: D shifted by two fraction widths
  localparam int NUM_W  = PROD_W + 2 * FRAC_BITS;
  // n*n with n up to MAX_SAMPLES
  localparam int DEN_W  = 25;
  localparam int ROOT_W = NUM_W / 2;

  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BAND_LOW     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BAND_HIGH    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MATCH_TARGET = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SPREAD_MODE  = 3'd4;

  localparam logic [1:0] STAT_OK       = 2'd0;
  localparam logic [1:0] STAT_EMPTY    = 2'd1;
  localparam logic [1:0] STAT_ONE      = 2'd2;
  localparam logic [1:0] STAT_OVERFLOW = 2'd3;

  typedef enum logic [3:0] {
    ST_ACC,
    ST_MUL,
    ST_SUB,
    ST_MDIV_GO,
    ST_MDIV_WAIT,
    ST_SDIV_GO,
    ST_SDIV_WAIT,
    ST_SQRT_GO,
    ST_SQRT_WAIT,
    ST_EMIT
  } state_e;

  typedef struct packed {
    logic acc;       // input beat accepted
    logic mul;       // form n*sumsq, sum^2, denominator
    logic sub;       // form D
    logic div_go;    // start divider
    logic div_mean;  // divider operands: mean (1) or spread (0)
    logic avg_ld;    // capture mean from divider
    logic sqrt_go;   // start square root
    logic emit;      // load result, clear set
  } cmd_t;

  typedef struct packed {
    logic n_zero;
    logic skip_spread;
    logic dev_mode;
    logic div_busy;
    logic sqrt_busy;
    logic out_free;
  } sts_t;

endpackage

// ===== hw/rtl/dsa_div.sv =====
// ----------------------------------------------------------------------------
// dsa_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module dsa_div import dsa_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  output logic             busy_o,
  output logic [NUM_W-1:0] quo_o,
  output logic             rem_nz_o
);

  localparam int CW = $clog2(NUM_W + 1);

  logic [CW-1:0]    cnt_q, cnt_d;
  logic [NUM_W-1:0] num_q, num_d;
  logic [DEN_W-1:0] rem_q, rem_d, den_q, den_d;
  logic [DEN_W:0]   trial, diff;
  logic             ge;

  assign trial = {rem_q, num_q[NUM_W-1]};
  assign diff  = trial - {1'b0, den_q};
  assign ge    = trial >= {1'b0, den_q};

  always_comb begin
    cnt_d = cnt_q;
    num_d = num_q;
    rem_d = rem_q;
    den_d = den_q;
    if (start_i) begin
      cnt_d = CW'(NUM_W);
      num_d = num_i;
      rem_d = '0;
      den_d = den_i;
    end else if (cnt_q != '0) begin
      cnt_d = cnt_q - 1'b1;
      num_d = {num_q[NUM_W-2:0], ge};
      rem_d = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    rem_q <= rem_d;
    den_q <= den_d;
  end

  assign busy_o   = cnt_q != '0;
  assign quo_o    = num_q;
  assign rem_nz_o = rem_q != '0;

endmodule

// ===== hw/rtl/dsa_sqrt.sv =====
// ----------------------------------------------------------------------------
// dsa_sqrt
// Digit-by-digit floor square root, one root bit per cycle.
// ----------------------------------------------------------------------------
module dsa_sqrt import dsa_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [NUM_W-1:0]  x_i,
  output logic              busy_o,
  output logic [ROOT_W-1:0] root_o
);

  localparam int CW    = $clog2(ROOT_W + 1);
  localparam int REM_W = ROOT_W + 2;

  logic [CW-1:0]     cnt_q, cnt_d;
  logic [NUM_W-1:0]  x_q, x_d;
  logic [REM_W-1:0]  rem_q, rem_d;
  logic [ROOT_W-1:0] root_q, root_d;
  logic [REM_W+1:0]  r2, trial, diff;
  logic              ge;

  assign r2    = {rem_q, x_q[NUM_W-1 -: 2]};
  assign trial = {2'b00, root_q, 2'b01};
  assign diff  = r2 - trial;
  assign ge    = r2 >= trial;

  always_comb begin
    cnt_d  = cnt_q;
    x_d    = x_q;
    rem_d  = rem_q;
    root_d = root_q;
    if (start_i) begin
      cnt_d  = CW'(ROOT_W);
      x_d    = x_i;
      rem_d  = '0;
      root_d = '0;
    end else if (cnt_q != '0) begin
      cnt_d  = cnt_q - 1'b1;
      x_d    = {x_q[NUM_W-3:0], 2'b00};
      rem_d  = ge ? diff[REM_W-1:0] : r2[REM_W-1:0];
      root_d = {root_q[ROOT_W-2:0], ge};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q    <= x_d;
    rem_q  <= rem_d;
    root_q <= root_d;
  end

  assign busy_o = cnt_q != '0;
  assign root_o = root_q;

endmodule

// ===== hw/rtl/dsa_ctrl.sv =====
// ----------------------------------------------------------------------------
// dsa_ctrl
// Sequencer: accumulate, then products, divides and (deviation modes) root at the set end.
// ----------------------------------------------------------------------------
module dsa_ctrl import dsa_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  input  logic last_i,
  output logic in_stall_o,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  state_e state_q, state_d;
  logic   accept;

  assign in_stall_o = state_q != ST_ACC;
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_ACC:       if (accept && last_i) state_d = ST_MUL;
      ST_MUL:       state_d = sts_i.n_zero ? ST_EMIT : ST_SUB;
      ST_SUB:       state_d = ST_MDIV_GO;
      ST_MDIV_GO:   state_d = ST_MDIV_WAIT;
      ST_MDIV_WAIT: begin
        if (!sts_i.div_busy) state_d = sts_i.skip_spread ? ST_EMIT : ST_SDIV_GO;
      end
      ST_SDIV_GO:   state_d = ST_SDIV_WAIT;
      ST_SDIV_WAIT: begin
        if (!sts_i.div_busy) state_d = sts_i.dev_mode ? ST_SQRT_GO : ST_EMIT;
      end
      ST_SQRT_GO:   state_d = ST_SQRT_WAIT;
      ST_SQRT_WAIT: if (!sts_i.sqrt_busy) state_d = ST_EMIT;
      ST_EMIT:      if (sts_i.out_free) state_d = ST_ACC;
      default:      state_d = ST_ACC;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    case (state_q)
      ST_ACC:       cmd_o.acc = accept;
      ST_MUL:       cmd_o.mul = 1'b1;
      ST_SUB:       cmd_o.sub = 1'b1;
      ST_MDIV_GO: begin
        cmd_o.div_go   = 1'b1;
        cmd_o.div_mean = 1'b1;
      end
      ST_MDIV_WAIT: cmd_o.avg_ld = !sts_i.div_busy;
      ST_SDIV_GO:   cmd_o.div_go = 1'b1;
      ST_SQRT_GO:   cmd_o.sqrt_go = 1'b1;
      ST_EMIT:      cmd_o.emit = sts_i.out_free;
      default:      cmd_o = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_ACC;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== hw/rtl/dsa_dpath.sv =====
// ----------------------------------------------------------------------------
// dsa_dpath
// Config registers, set accumulators, end-of-set arithmetic, result register.
// ----------------------------------------------------------------------------
module dsa_dpath import dsa_pkg::*; (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_valid_i,
  input  logic [CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [SAMPLE_W-1:0]        cfg_data_i,
  input  logic signed [SAMPLE_W-1:0] sample_i,
  input  logic                       has_sample_i,
  input  logic                       out_stall_i,
  input  cmd_t                       cmd_i,
  output sts_t                       sts_o,
  output logic                       out_valid_o,
  output logic [CNT_W-1:0]           sample_count_o,
  output logic signed [SUM_W-1:0]    total_o,
  output logic [SQ_W-1:0]            total_squares_o,
  output logic signed [SAMPLE_W-1:0] smallest_o,
  output logic signed [SAMPLE_W-1:0] largest_o,
  output logic signed [AVG_W-1:0]    average_o,
  output logic [SPR_W-1:0]           spread_o,
  output logic [CNT_W-1:0]           above_count_o,
  output logic [CNT_W-1:0]           below_count_o,
  output logic [CNT_W-1:0]           band_count_o,
  output logic [CNT_W-1:0]           equal_count_o,
  output logic [1:0]                 status_o
);

  localparam logic signed [SAMPLE_W-1:0] SMAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
  localparam logic signed [SAMPLE_W-1:0] SMIN = {1'b1, {(SAMPLE_W-1){1'b0}}};

  // configuration
  logic signed [SAMPLE_W-1:0] threshold_q, band_low_q, band_high_q, match_q;
  logic [1:0]                 mode_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      threshold_q <= '0;
      band_low_q  <= '0;
      band_high_q <= '0;
      match_q     <= '0;
      mode_q      <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_THRESHOLD:    threshold_q <= cfg_data_i;
        CFG_BAND_LOW:     band_low_q  <= cfg_data_i;
        CFG_BAND_HIGH:    band_high_q <= cfg_data_i;
        CFG_MATCH_TARGET: match_q     <= cfg_data_i;
        CFG_SPREAD_MODE:  mode_q      <= cfg_data_i[1:0];
        default:          ;
      endcase
    end
  end

  // accumulators
  logic [CNT_W-1:0]           count_q, above_q, below_q, band_q, equal_q;
  logic signed [SUM_W-1:0]    sum_q;
  logic [SQ_W-1:0]            sumsq_q;
  logic signed [SAMPLE_W-1:0] min_q, max_q;
  logic                       ovf_q;
  logic signed [2*SAMPLE_W-1:0] sq;
  logic                       full, take;

  assign sq   = sample_i * sample_i;
  assign full = count_q >= CNT_W'(MAX_SAMPLES);
  assign take = cmd_i.acc && has_sample_i && !full;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      sum_q   <= '0;
      sumsq_q <= '0;
      min_q   <= SMAX;
      max_q   <= SMIN;
      above_q <= '0;
      below_q <= '0;
      band_q  <= '0;
      equal_q <= '0;
      ovf_q   <= 1'b0;
    end else if (cmd_i.emit) begin
      count_q <= '0;
      sum_q   <= '0;
      sumsq_q <= '0;
      min_q   <= SMAX;
      max_q   <= SMIN;
      above_q <= '0;
      below_q <= '0;
      band_q  <= '0;
      equal_q <= '0;
      ovf_q   <= 1'b0;
    end else if (take) begin
      count_q <= count_q + 1'b1;
      sum_q   <= sum_q + {{(SUM_W-SAMPLE_W){sample_i[SAMPLE_W-1]}}, sample_i};
      sumsq_q <= sumsq_q + {{(SQ_W-2*SAMPLE_W){1'b0}}, sq};
      if (sample_i < min_q) min_q <= sample_i;
      if (sample_i > max_q) max_q <= sample_i;
      if (sample_i > threshold_q) above_q <= above_q + 1'b1;
      if (sample_i < threshold_q) below_q <= below_q + 1'b1;
      if (sample_i >= band_low_q && sample_i <= band_high_q) band_q <= band_q + 1'b1;
      if (sample_i == match_q) equal_q <= equal_q + 1'b1;
    end else if (cmd_i.acc && has_sample_i) begin
      ovf_q <= 1'b1;
    end
  end

  // end-of-set arithmetic
  logic                neg, n_zero, n_one, sample_mode, dev_mode, skip;
  logic [SUM_W-1:0]    mag;
  logic [PROD_W-1:0]   p1_q, p2_q, d_q;
  logic [DEN_W-1:0]    den_q;
  logic [CNT_W-1:0]    n_m1;
  logic [2*CNT_W-1:0]  den_full;
  logic signed [AVG_W-1:0] avg_q;

  assign neg         = sum_q[SUM_W-1];
  assign mag         = neg ? -sum_q : sum_q;
  assign n_zero      = count_q == '0;
  assign n_one       = count_q == CNT_W'(1);
  assign sample_mode = mode_q[0];
  assign dev_mode    = mode_q[1];
  assign skip        = n_one && sample_mode;
  assign n_m1        = count_q - 1'b1;
  assign den_full    = count_q * (sample_mode ? n_m1 : count_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul) begin
      p1_q  <= count_q * sumsq_q;
      p2_q  <= mag * mag;
      den_q <= den_full[DEN_W-1:0];
    end
    if (cmd_i.sub) d_q <= p1_q - p2_q;
  end

  logic [NUM_W-1:0]  div_num, quo, mean_num, spr_num;
  logic [DEN_W-1:0]  div_den;
  logic              div_busy, rem_nz, sqrt_busy;
  logic [ROOT_W-1:0] root;

  assign mean_num = {{(NUM_W-SUM_W-FRAC_BITS){1'b0}}, mag, {FRAC_BITS{1'b0}}};
  assign spr_num  = dev_mode ? {d_q, {(2*FRAC_BITS){1'b0}}}
                             : {{FRAC_BITS{1'b0}}, d_q, {FRAC_BITS{1'b0}}};
  assign div_num  = cmd_i.div_mean ? mean_num : spr_num;
  assign div_den  = cmd_i.div_mean ? {{(DEN_W-CNT_W){1'b0}}, count_q} : den_q;

  dsa_div u_div (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (cmd_i.div_go),
    .num_i    (div_num),
    .den_i    (div_den),
    .busy_o   (div_busy),
    .quo_o    (quo),
    .rem_nz_o (rem_nz)
  );

  dsa_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.sqrt_go),
    .x_i     (quo),
    .busy_o  (sqrt_busy),
    .root_o  (root)
  );

  // negative mean floors away from zero when the divide is inexact
  logic [AVG_W-1:0] q_adj;
  assign q_adj = quo[AVG_W-1:0] + {{(AVG_W-1){1'b0}}, rem_nz};

  always_ff @(posedge clk_i) begin
    if (cmd_i.avg_ld) avg_q <= neg ? -q_adj : quo[AVG_W-1:0];
  end

  // result register
  logic out_valid_q;
  logic [SPR_W-1:0] spr_val;

  assign spr_val = dev_mode ? {{(SPR_W-ROOT_W){1'b0}}, root} : quo[SPR_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      sample_count_o  <= count_q;
      total_o         <= sum_q;
      total_squares_o <= sumsq_q;
      smallest_o      <= n_zero ? '0 : min_q;
      largest_o       <= n_zero ? '0 : max_q;
      average_o       <= n_zero ? '0 : avg_q;
      spread_o        <= (n_zero || skip) ? '0 : spr_val;
      above_count_o   <= above_q;
      below_count_o   <= below_q;
      band_count_o    <= band_q;
      equal_count_o   <= equal_q;
      if (ovf_q)       status_o <= STAT_OVERFLOW;
      else if (n_zero) status_o <= STAT_EMPTY;
      else if (skip)   status_o <= STAT_ONE;
      else             status_o <= STAT_OK;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign sts_o.n_zero      = n_zero;
  assign sts_o.skip_spread = skip;
  assign sts_o.dev_mode    = dev_mode;
  assign sts_o.div_busy    = div_busy;
  assign sts_o.sqrt_busy   = sqrt_busy;
  assign sts_o.out_free    = !out_valid_q || !out_stall_i;

endmodule

// ===== hw/rtl/descriptive_stats_accumulator_core.sv =====
// ----------------------------------------------------------------------------
// descriptive_stats_accumulator_core
// Streaming statistics over a set of signed samples, result at set end.
//
//   channel  direction  handshake           beat
//   in       input      in_valid/in_stall   sample, has_sample, last
//   out      output     out_valid/out_stall one result of 12 fields
//   cfg      input      cfg_valid/cfg_ready register index, 16-bit data
//
// A beat without last is taken without a stall. A last beat then stalls the
// input for the products, the mean divide, the spread divide (not for one
// sample in sample mode), the root in deviation modes and the result load,
// in that order. An empty set goes from the products straight to the result
// load. The result register lets the next set stream in while a result waits;
// a stalled result only holds the next set end.
// Reset is asynchronous and clears all control and accumulator state.
// ----------------------------------------------------------------------------
module descriptive_stats_accumulator_core import dsa_pkg::*; (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [SAMPLE_W-1:0]        cfg_data_i,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic signed [SAMPLE_W-1:0] sample_i,
  input  logic                       has_sample_i,
  input  logic                       last_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [CNT_W-1:0]           sample_count_o,
  output logic signed [SUM_W-1:0]    total_o,
  output logic [SQ_W-1:0]            total_squares_o,
  output logic signed [SAMPLE_W-1:0] smallest_o,
  output logic signed [SAMPLE_W-1:0] largest_o,
  output logic signed [AVG_W-1:0]    average_o,
  output logic [SPR_W-1:0]           spread_o,
  output logic [CNT_W-1:0]           above_count_o,
  output logic [CNT_W-1:0]           below_count_o,
  output logic [CNT_W-1:0]           band_count_o,
  output logic [CNT_W-1:0]           equal_count_o,
  output logic [1:0]                 status_o
);

  cmd_t cmd;
  sts_t sts;

  assign cfg_ready_o = 1'b1;

  dsa_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .last_i     (last_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  dsa_dpath u_dpath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .sample_i        (sample_i),
    .has_sample_i    (has_sample_i),
    .out_stall_i     (out_stall_i),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .out_valid_o     (out_valid_o),
    .sample_count_o  (sample_count_o),
    .total_o         (total_o),
    .total_squares_o (total_squares_o),
    .smallest_o      (smallest_o),
    .largest_o       (largest_o),
    .average_o       (average_o),
    .spread_o        (spread_o),
    .above_count_o   (above_count_o),
    .below_count_o   (below_count_o),
    .band_count_o    (band_count_o),
    .equal_count_o   (equal_count_o),
    .status_o        (status_o)
  );

endmodule

// ===== hw/rtl/dsa_checker.sv =====
// ----------------------------------------------------------------------------
// dsa_checker
// Port-level checks on the result channel, bound to the core.
// ----------------------------------------------------------------------------
module dsa_checker import dsa_pkg::*; (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       out_valid_o,
  input logic                       out_stall_i,
  input logic [CNT_W-1:0]           sample_count_o,
  input logic signed [SUM_W-1:0]    total_o,
  input logic signed [SAMPLE_W-1:0] smallest_o,
  input logic signed [SAMPLE_W-1:0] largest_o,
  input logic signed [AVG_W-1:0]    average_o,
  input logic [SPR_W-1:0]           spread_o,
  input logic [CNT_W-1:0]           above_count_o,
  input logic [CNT_W-1:0]           below_count_o,
  input logic [1:0]                 status_o
);

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(total_o) && $stable(spread_o))
    else $error("stalled result beat changed");

  a_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == STAT_EMPTY |->
      sample_count_o == '0 && average_o == '0 && spread_o == '0)
    else $error("empty set result not cleared");

  a_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == STAT_OK || status_o == STAT_ONE) |->
      sample_count_o != '0 && smallest_o <= largest_o)
    else $error("min above max");

  a_split: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ({1'b0, above_count_o} + {1'b0, below_count_o}) <= {1'b0, sample_count_o})
    else $error("above plus below exceeds count");

  a_ovf: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == STAT_OVERFLOW |-> sample_count_o == CNT_W'(MAX_SAMPLES))
    else $error("overflow flagged below full set");

endmodule

bind descriptive_stats_accumulator_core dsa_checker u_dsa_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid_o    (out_valid_o),
  .out_stall_i    (out_stall_i),
  .sample_count_o (sample_count_o),
  .total_o        (total_o),
  .smallest_o     (smallest_o),
  .largest_o      (largest_o),
  .average_o      (average_o),
  .spread_o       (spread_o),
  .above_count_o  (above_count_o),
  .below_count_o  (below_count_o),
  .status_o       (status_o)
);
